// File: rtl/core/pdc_pkg.sv
// pdc_pkg: shared types and constants of the PD controller.
// Payload structs, op codes, register indexes and datapath widths.
// No dependencies.
package pdc_pkg;

  localparam int GAIN_W = 15;  // magnitude bits of a valid (non-negative) gain
  localparam int MAG_W  = 36;  // widest multiplicand: rate quotient
  localparam int ACC_W  = 53;  // signed sum of P and D terms, Q45.8
  localparam int DVD_W  = 36;  // dividend |diff| * 1e6
  localparam int DVS_W  = 16;  // divisor dt_us
  localparam int CFG_IDX_W = 2;

  localparam logic [19:0] US_PER_S = 20'd1000000;

  localparam logic [1:0] OP_RATE   = 2'd0;
  localparam logic [1:0] OP_MEAS   = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN = 2'd1;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] error_value;
    logic signed [15:0] rate_value;
    logic [15:0]        dt_us;
  } in_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic              clear;
    logic              start;
    logic              neg;
    logic [GAIN_W-1:0] gain;
    logic [MAG_W-1:0]  mag;
  } mac_cmd_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_cmd_t;

endpackage

// File: rtl/core/pd_controller_unit.sv
// pd_controller_unit: fixed-point PD controller, top level.
// Sequencer around pdc_mac and pdc_div; types from pdc_pkg.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   pdc_pkg::in_t (op, error, rate, dt)
//   out_     output     out_valid / out_stall pdc_pkg::out_t (drive, saturated)
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data (gains)
//
// One item at a time. Op 3 or invalid gains go straight to the output. Ops 0 and 1:
// two passes of the 15-step serial multiplier, each ending early on spent gain bits. Op 2 with a
// derivative: the 36-step divider, overlapped by the P multiply, followed by one multiply.
// Synchronous active-low reset clears gains, history and all control state.
// A finished result sits in the output register; the next item is taken while
// it waits, and a stalled output only holds up the end of the following item.
module pd_controller_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pdc_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pdc_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_P    = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_D    = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam int AW = pdc_pkg::ACC_W;

  logic [2:0]  state_r, state_nxt;
  logic [15:0] p_gain_r, d_gain_r;
  logic [15:0] prev_r;
  logic        hist_r;
  logic [1:0]  op_r;
  logic [15:0] rate_mag_r;
  logic        d_neg_r;
  logic        use_d_r;
  logic        out_valid_r, out_valid_nxt;
  pdc_pkg::out_t out_data_r;

  logic        accept, gains_ok, out_wr;
  logic [15:0] err_mag, rate_mag;
  logic [16:0] diff, diff_mag;
  logic        start_div;

  pdc_pkg::mac_cmd_t mac_cmd;
  pdc_pkg::div_cmd_t div_cmd;
  logic              mac_busy, div_busy;
  logic [AW-1:0]     acc;
  logic [pdc_pkg::DVD_W-1:0] quotient;

  pdc_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (mac_cmd),
    .busy (mac_busy),
    .acc  (acc)
  );

  pdc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (div_cmd),
    .busy    (div_busy),
    .quotient(quotient)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign gains_ok  = !p_gain_r[15] && !d_gain_r[15];

  assign err_mag  = in_data.error_value[15] ? (~in_data.error_value + 16'd1)
                                            : in_data.error_value;
  assign rate_mag = in_data.rate_value[15] ? (~in_data.rate_value + 16'd1)
                                           : in_data.rate_value;
  assign diff     = {in_data.error_value[15], in_data.error_value} - {prev_r[15], prev_r};
  assign diff_mag = diff[16] ? (~diff + 17'd1) : diff;

  assign start_div = accept && (in_data.op == pdc_pkg::OP_SAMPLE) && gains_ok && hist_r
                     && (in_data.dt_us > 16'd1);

  assign div_cmd.start    = start_div;
  assign div_cmd.dividend = pdc_pkg::DVD_W'({19'd0, diff_mag} * {16'd0, pdc_pkg::US_PER_S});
  assign div_cmd.divisor  = in_data.dt_us;

  assign out_wr = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    mac_cmd.clear = 1'b0;
    mac_cmd.start = 1'b0;
    mac_cmd.neg   = 1'b0;
    mac_cmd.gain  = p_gain_r[pdc_pkg::GAIN_W-1:0];
    mac_cmd.mag   = {20'd0, err_mag};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mac_cmd.clear = 1'b1;
          if (in_data.op == pdc_pkg::OP_CLEAR || !gains_ok) begin
            state_nxt = S_DONE;
          end else begin
            mac_cmd.start = 1'b1;
            mac_cmd.neg   = in_data.error_value[15];
            state_nxt     = S_P;
          end
        end
      end
      S_P: begin
        if (!mac_busy) begin
          if (op_r == pdc_pkg::OP_SAMPLE) begin
            state_nxt = use_d_r ? S_DIV : S_DONE;
          end else begin
            mac_cmd.start = 1'b1;
            mac_cmd.neg   = d_neg_r;
            mac_cmd.gain  = d_gain_r[pdc_pkg::GAIN_W-1:0];
            mac_cmd.mag   = {20'd0, rate_mag_r};
            state_nxt     = S_D;
          end
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          mac_cmd.start = 1'b1;
          mac_cmd.neg   = d_neg_r;
          mac_cmd.gain  = d_gain_r[pdc_pkg::GAIN_W-1:0];
          mac_cmd.mag   = quotient;
          state_nxt     = S_D;
        end
      end
      S_D: begin
        if (!mac_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_wr) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_wr || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      p_gain_r    <= '0;
      d_gain_r    <= '0;
      prev_r      <= '0;
      hist_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pdc_pkg::REG_P_GAIN) begin
          p_gain_r <= cfg_data;
        end
        if (cfg_index == pdc_pkg::REG_D_GAIN) begin
          d_gain_r <= cfg_data;
        end
      end
      if (accept) begin
        if (in_data.op == pdc_pkg::OP_CLEAR
            || (in_data.op == pdc_pkg::OP_SAMPLE && !gains_ok)) begin
          prev_r <= '0;
          hist_r <= 1'b0;
        end else if (in_data.op == pdc_pkg::OP_SAMPLE) begin
          prev_r <= in_data.error_value;
          hist_r <= 1'b1;
        end
      end
    end
  end

  // item context, taken on the input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_data.op;
      rate_mag_r <= rate_mag;
      use_d_r    <= start_div;
      if (in_data.op == pdc_pkg::OP_SAMPLE) begin
        d_neg_r <= diff[16];
      end else begin
        d_neg_r <= in_data.rate_value[15] ^ (in_data.op == pdc_pkg::OP_MEAS);
      end
    end
  end

  // floor shift by 8 is a plain bit select; clip when the dropped top bits disagree
  always_ff @(posedge clk) begin
    if (out_wr) begin
      if (acc[AW-1:39] != {(AW - 39){acc[AW-1]}}) begin
        out_data_r.drive     <= acc[AW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        out_data_r.saturated <= 1'b1;
      end else begin
        out_data_r.drive     <= acc[39:8];
        out_data_r.saturated <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/pdc_mac.sv
// pdc_mac: serial shift-add multiply-accumulate, one gain bit per cycle.
// acc += (neg ? -1 : 1) * gain * mag. Depends on pdc_pkg.
module pdc_mac (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pdc_pkg::mac_cmd_t        cmd,
  output logic                     busy,
  output logic [pdc_pkg::ACC_W-1:0] acc
);

  localparam int SH_W = pdc_pkg::MAG_W + pdc_pkg::GAIN_W;

  logic [pdc_pkg::GAIN_W-1:0] gain_r, gain_nxt;
  logic [SH_W-1:0]            mag_r, mag_nxt;
  logic                       neg_r, neg_nxt;
  logic [pdc_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [pdc_pkg::ACC_W-1:0]  addend;

  assign addend = {{(pdc_pkg::ACC_W - SH_W){1'b0}}, mag_r};

  always_comb begin
    gain_nxt = gain_r >> 1;
    mag_nxt  = mag_r << 1;
    neg_nxt  = neg_r;
    if (cmd.clear) begin
      acc_nxt = '0;
    end else if (gain_r[0]) begin
      acc_nxt = neg_r ? (acc_r - addend) : (acc_r + addend);
    end else begin
      acc_nxt = acc_r;
    end
    if (cmd.start) begin
      gain_nxt = cmd.gain;
      mag_nxt  = {{pdc_pkg::GAIN_W{1'b0}}, cmd.mag};
      neg_nxt  = cmd.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
    end else begin
      gain_r <= gain_nxt;
    end
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    acc_r <= acc_nxt;
  end

  // finishes early once the remaining gain bits are zero
  assign busy = (gain_r != '0);
  assign acc  = acc_r;

endmodule

// File: rtl/core/pdc_div.sv
// pdc_div: restoring unsigned divider, one quotient bit per cycle.
// Dividend shifts out the top while quotient bits shift in. Depends on pdc_pkg.
module pdc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pdc_pkg::div_cmd_t         cmd,
  output logic                      busy,
  output logic [pdc_pkg::DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(pdc_pkg::DVD_W + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(pdc_pkg::DVD_W);

  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [pdc_pkg::DVD_W-1:0]   quo_r, quo_nxt;
  logic [pdc_pkg::DVS_W-1:0]   rem_r, rem_nxt;
  logic [pdc_pkg::DVS_W-1:0]   dvs_r, dvs_nxt;
  logic [pdc_pkg::DVS_W+1:0]   trial;
  logic [pdc_pkg::DVS_W:0]     shifted;

  assign shifted = {rem_r, quo_r[pdc_pkg::DVD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};

  always_comb begin
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    if (cmd.start) begin
      cnt_nxt = STEPS;
      quo_nxt = cmd.dividend;
      rem_nxt = '0;
      dvs_nxt = cmd.divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      // no borrow: the divisor fits, take the difference
      if (!trial[pdc_pkg::DVS_W+1]) begin
        rem_nxt = trial[pdc_pkg::DVS_W-1:0];
        quo_nxt = {quo_r[pdc_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[pdc_pkg::DVS_W-1:0];
        quo_nxt = {quo_r[pdc_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

// File: verif/pd_controller_unit_tb.sv
// pd_controller_unit_tb: self-checking testbench for the fixed-point PD controller.
// Directed and random ops under random gain settings, with random input gaps and output stalls.
// Depends on pdc_pkg and pd_controller_unit.
module pd_controller_unit_tb;

  localparam logic [pdc_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [pdc_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 100;

  // Holds the gains and history of the controller and the drives they imply.
  class drive_scoreboard;
    logic signed [15:0] kp;
    logic signed [15:0] kd;
    logic signed [15:0] last_error;
    bit                 have_history;
    pdc_pkg::out_t      expected_drives[$];
    int failures;
    int results_seen;
    int n_items;
    int n_cfg;
    int n_derivative;
    int n_saturated;
    int n_invalid;

    function new();
      kp = '0;
      kd = '0;
      last_error = '0;
      have_history = 1'b0;
      failures = 0;
      results_seen = 0;
      n_items = 0;
      n_cfg = 0;
      n_derivative = 0;
      n_saturated = 0;
      n_invalid = 0;
    endfunction

    function void write_reg(logic [pdc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
      n_cfg++;
      case (idx)
        pdc_pkg::REG_P_GAIN: kp = value;
        pdc_pkg::REG_D_GAIN: kd = value;
        default: ;  // unmapped index, no effect
      endcase
    endfunction

    function pdc_pkg::out_t predict_drive(pdc_pkg::in_t it);
      longint err;
      longint rate;
      longint dt;
      longint sum;
      longint slope;
      longint shifted;
      pdc_pkg::out_t r;
      err = longint'($signed(it.error_value));
      rate = longint'($signed(it.rate_value));
      dt = longint'(it.dt_us);
      r = '0;
      if (it.op == pdc_pkg::OP_CLEAR) begin
        last_error = '0;
        have_history = 1'b0;
        return r;
      end
      if (kp[15] || kd[15]) begin
        n_invalid++;
        if (it.op == pdc_pkg::OP_SAMPLE) begin
          last_error = '0;
          have_history = 1'b0;
        end
        return r;
      end
      sum = longint'(kp) * err;
      case (it.op)
        pdc_pkg::OP_RATE: sum = sum + longint'(kd) * rate;
        pdc_pkg::OP_MEAS: sum = sum - longint'(kd) * rate;
        default: begin
          if (have_history && dt > 1) begin
            // signed division truncates toward zero
            slope = ((err - longint'(last_error)) * 64'sd1000000) / dt;
            sum = sum + longint'(kd) * slope;
            n_derivative++;
          end
          last_error = it.error_value;
          have_history = 1'b1;
        end
      endcase
      shifted = sum >>> 8;
      if (shifted > 64'sd2147483647) begin
        r.drive = 32'h7fff_ffff;
        r.saturated = 1'b1;
      end else if (shifted < -64'sd2147483648) begin
        r.drive = 32'h8000_0000;
        r.saturated = 1'b1;
      end else begin
        r.drive = 32'(shifted);
      end
      return r;
    endfunction

    function void note_input(pdc_pkg::in_t it);
      n_items++;
      expected_drives.push_back(predict_drive(it));
    endfunction

    function void check_result(pdc_pkg::out_t got);
      pdc_pkg::out_t want;
      results_seen++;
      if (expected_drives.size() == 0) begin
        $error("unexpected result: drive %0d saturated %0b", $signed(got.drive), got.saturated);
        failures++;
        return;
      end
      want = expected_drives.pop_front();
      if (want.saturated) n_saturated++;
      if (got.drive !== want.drive) begin
        $error("drive mismatch: expected %0d, actual %0d", $signed(want.drive),
               $signed(got.drive));
        failures++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated mismatch: expected %0b, actual %0b", want.saturated, got.saturated);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  pdc_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall;
  pdc_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [pdc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  drive_scoreboard sb = new();
  int idle_level;
  int stall_left;
  int items_sent;
  int quiet_cycles;
  logic [15:0] last_sample;

  pd_controller_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Transfer monitor and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("pd_controller_unit regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Output backpressure in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_level > 0 && $urandom_range(0, 99) < idle_level) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic pdc_pkg::in_t mk(logic [1:0] op, logic [15:0] err, logic [15:0] rate,
                                      logic [15:0] dt);
    pdc_pkg::in_t it;
    it.op = op;
    it.error_value = err;
    it.rate_value = rate;
    it.dt_us = dt;
    return it;
  endfunction

  function automatic pdc_pkg::in_t rand_item();
    pdc_pkg::in_t it;
    int pick;
    logic [15:0] e;
    pick = $urandom_range(0, 99);
    if (pick < 50) it.op = pdc_pkg::OP_SAMPLE;
    else if (pick < 70) it.op = pdc_pkg::OP_RATE;
    else if (pick < 90) it.op = pdc_pkg::OP_MEAS;
    else it.op = pdc_pkg::OP_CLEAR;
    case ($urandom_range(0, 3))
      0: e = 16'($urandom);
      1: e = last_sample + 16'($urandom_range(0, 64)) - 16'd32;  // slow drift
      2: e = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: e = 16'($urandom_range(0, 2047)) - 16'd1024;
    endcase
    if (it.op == pdc_pkg::OP_SAMPLE) last_sample = e;
    it.error_value = e;
    it.rate_value = 16'($urandom);
    case ($urandom_range(0, 7))
      0: it.dt_us = 16'($urandom_range(0, 2));
      1, 2: it.dt_us = 16'($urandom);
      default: it.dt_us = 16'($urandom_range(2, 2000));
    endcase
    return it;
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h7fff;
      2: return 16'h8000;
      3: return 16'hffff;
      4, 5, 6: return 16'($urandom_range(0, 1023));
      default: return {1'b0, 15'($urandom)};
    endcase
  endfunction

  // Leaves in_valid high after the transfer; drain(), or a gap in the next call, lowers it.
  task automatic send(pdc_pkg::in_t it);
    int gap;
    gap = 0;
    if (idle_level > 0 && $urandom_range(0, 99) < idle_level) gap = $urandom_range(1, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.results_seen < items_sent) @(posedge clk);
  endtask

  task automatic cfg_put(logic [pdc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Call only with the block idle.
  task automatic set_gains(logic [15:0] p, logic [15:0] d);
    cfg_put(pdc_pkg::REG_P_GAIN, p);
    cfg_put(pdc_pkg::REG_D_GAIN, d);
    if ($urandom_range(0, 3) == 0) cfg_put($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                                           16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_level = 0;
    stall_left = 0;
    items_sent = 0;
    quiet_cycles = 0;
    last_sample = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unity P gain, half D gain: history, short intervals, field extremes.
    idle_level = 15;
    set_gains(16'h0100, 16'h0080);
    send(mk(pdc_pkg::OP_SAMPLE, 16'h0100, 16'h0000, 16'd1000));  // no history yet
    send(mk(pdc_pkg::OP_SAMPLE, 16'h0200, 16'h0000, 16'd1000));
    send(mk(pdc_pkg::OP_SAMPLE, 16'h0300, 16'h0000, 16'd1));     // too short for a slope
    send(mk(pdc_pkg::OP_SAMPLE, 16'h0100, 16'h0000, 16'd0));
    send(mk(pdc_pkg::OP_SAMPLE, 16'h8000, 16'hffff, 16'hffff));
    send(mk(pdc_pkg::OP_RATE, 16'h7fff, 16'h7fff, 16'h0000));
    send(mk(pdc_pkg::OP_RATE, 16'h8000, 16'h8000, 16'hffff));
    send(mk(pdc_pkg::OP_MEAS, 16'h7fff, 16'h8000, 16'h0000));
    send(mk(pdc_pkg::OP_MEAS, 16'h8000, 16'h7fff, 16'hffff));
    send(mk(pdc_pkg::OP_CLEAR, 16'h7fff, 16'h7fff, 16'hffff));
    send(mk(pdc_pkg::OP_SAMPLE, 16'h0500, 16'h0000, 16'd100));   // history was cleared
    drain();

    // Full-scale gains: large slopes clip both ways.
    set_gains(16'h7fff, 16'h7fff);
    send(mk(pdc_pkg::OP_SAMPLE, 16'h8000, 16'h0000, 16'd2));
    send(mk(pdc_pkg::OP_SAMPLE, 16'h7fff, 16'h0000, 16'd2));
    send(mk(pdc_pkg::OP_SAMPLE, 16'h8000, 16'h0000, 16'd2));
    send(mk(pdc_pkg::OP_SAMPLE, 16'h8000, 16'h0000, 16'hffff));
    drain();

    // Negative gains zero the drive; a sample also drops the history.
    set_gains(16'hffff, 16'h0100);
    @(posedge clk);
    cfg_put(REG_SPARE_A, 16'h1234);
    cfg_put(REG_SPARE_B, 16'hfedc);
    cfg_valid <= 1'b0;
    send(mk(pdc_pkg::OP_RATE, 16'h0400, 16'h0400, 16'd0));
    send(mk(pdc_pkg::OP_MEAS, 16'h0400, 16'h0400, 16'd0));
    send(mk(pdc_pkg::OP_SAMPLE, 16'h0400, 16'h0000, 16'd500));
    drain();
    set_gains(16'h0100, 16'h8000);
    send(mk(pdc_pkg::OP_SAMPLE, 16'h0005, 16'h0000, 16'd10));
    drain();
    set_gains(16'h0000, 16'h0000);
    send(mk(pdc_pkg::OP_SAMPLE, 16'h0064, 16'h0000, 16'd50));
    send(mk(pdc_pkg::OP_SAMPLE, 16'hff9c, 16'h0000, 16'd50));
    drain();
    set_gains(16'h7fff, 16'h0000);
    send(mk(pdc_pkg::OP_RATE, 16'h8000, 16'h5a5a, 16'ha5a5));
    drain();

    // Random phases; the last ones run without gaps or stalls.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: idle_level = 0;
        1: idle_level = 10;
        2: idle_level = 30;
        default: idle_level = 60;
      endcase
      if (ph >= RANDOM_PHASES - 2) idle_level = 0;
      set_gains(rand_gain(), rand_gain());
      for (int n = 0; n < PHASE_ITEMS; n++) send(rand_item());
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_drives.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_drives.size());
      sb.failures++;
    end
    $display("ran %0d items and %0d register writes: %0d slope samples, %0d clipped drives,",
             sb.n_items, sb.n_cfg, sb.n_derivative, sb.n_saturated);
    $display("%0d items under invalid gains, %0d mismatches", sb.n_invalid, sb.failures);
    if (sb.failures == 0) begin
      $display("pd_controller_unit regression: pass");
    end else begin
      $display("pd_controller_unit regression: fail");
    end
    $finish;
  end

endmodule
